>>> rtl/core/ptt_pkg.sv
// shared types, codes and constants of the priority sorted task table
`default_nettype none
package ptt_pkg;

  localparam int unsigned DEPTH_DEF  = 16;
  localparam int unsigned ID_W_DEF   = 16;
  localparam int unsigned IN_ID_W    = 16;
  localparam int unsigned PRIO_W     = 2;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_CNT_W  = 5;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_PRIO  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [PRIO_W-1:0] PRIO_NONE = 2'd0;

  typedef struct packed {
    logic do_ins;
    logic do_rem;
  } ptt_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/ptt_cell.sv
// one table slot: holds an id and a priority, shifts with its neighbors
`default_nettype none
module ptt_cell #(
  parameter int unsigned ID_BITS = ptt_pkg::ID_W_DEF
) (
  input  wire logic                        clk,
  input  wire ptt_pkg::ptt_ctrl_t          ctrl,
  input  wire logic [ID_BITS-1:0]          key_id,
  input  wire logic [ptt_pkg::PRIO_W-1:0]  key_prio,
  input  wire logic                        occ,
  input  wire logic                        prev_after,
  output logic                             after_o,
  input  wire logic                        hit_in,
  output logic                             hit_out,
  input  wire logic [ID_BITS-1:0]          prev_id,
  input  wire logic [ptt_pkg::PRIO_W-1:0]  prev_prio,
  input  wire logic [ID_BITS-1:0]          next_id,
  input  wire logic [ptt_pkg::PRIO_W-1:0]  next_prio,
  output logic [ID_BITS-1:0]               id_o,
  output logic [ptt_pkg::PRIO_W-1:0]       prio_o
);

  logic [ID_BITS-1:0]         id_r;
  logic [ID_BITS-1:0]         id_nxt;
  logic [ptt_pkg::PRIO_W-1:0] prio_r;
  logic [ptt_pkg::PRIO_W-1:0] prio_nxt;
  logic                       match;

  // slot is at or after the insert point
  assign after_o = !occ || (prio_r > key_prio);
  assign match   = occ && (id_r == key_id);
  assign hit_out = hit_in || match;

  always_comb begin
    id_nxt   = id_r;
    prio_nxt = prio_r;
    if (ctrl.do_ins) begin
      if (prev_after) begin
        id_nxt   = prev_id;
        prio_nxt = prev_prio;
      end else if (after_o) begin
        id_nxt   = key_id;
        prio_nxt = key_prio;
      end
    end else if (ctrl.do_rem && hit_out) begin
      id_nxt   = next_id;
      prio_nxt = next_prio;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

  assign id_o   = id_r;
  assign prio_o = prio_r;

endmodule
`default_nettype wire

>>> rtl/core/priority_sorted_task_table.sv
// top level: sorted task table built from a chain of slot cells
// the accepting edge latches the operands and sets busy; the execute cycle updates the
// chain and registers the result beat; no new command is taken while busy is high
// the remove search ripples a hit flag combinationally through the whole cell chain
// results cannot be stalled; out_valid is high for exactly one cycle per command
// synchronous active-low reset empties the table and clears busy and the strobe
`default_nettype none
module priority_sorted_task_table #(
  parameter int unsigned TABLE_DEPTH = ptt_pkg::DEPTH_DEF,
  parameter int unsigned ID_BITS     = ptt_pkg::ID_W_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [ptt_pkg::KIND_W-1:0]       in_kind,
  input  wire logic [ptt_pkg::IN_ID_W-1:0]      in_task_id,
  input  wire logic [ptt_pkg::PRIO_W-1:0]       in_task_priority,
  output logic                                  out_valid,
  output logic                                  out_accepted,
  output logic [ptt_pkg::STATUS_W-1:0]          out_status,
  output logic [ptt_pkg::OUT_CNT_W-1:0]         out_entry_count
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  logic                           busy_r;
  logic                           busy_nxt;
  logic [ptt_pkg::KIND_W-1:0]     kind_r;
  logic [ID_BITS-1:0]             key_id_r;
  logic [ID_BITS-1:0]             key_id_in;
  logic [ptt_pkg::PRIO_W-1:0]     key_prio_r;
  logic [CNT_W-1:0]               count_r;
  logic [CNT_W-1:0]               count_nxt;
  logic                           out_valid_r;
  logic                           out_acc_r;
  logic                           out_acc_nxt;
  logic [ptt_pkg::STATUS_W-1:0]   out_status_r;
  logic [ptt_pkg::STATUS_W-1:0]   out_status_nxt;
  logic                           take;
  logic                           full;
  logic                           found;
  ptt_pkg::ptt_ctrl_t             ctrl;

  logic [TABLE_DEPTH-1:0]         occ;
  logic [TABLE_DEPTH-1:0]         after;
  logic [TABLE_DEPTH-1:0]         hit;
  logic [ID_BITS-1:0]             cell_id   [TABLE_DEPTH];
  logic [ptt_pkg::PRIO_W-1:0]     cell_prio [TABLE_DEPTH];

  assign take = start && !busy_r;
  assign busy = busy_r;
  assign full = (count_r == CNT_FULL);
  assign found = hit[TABLE_DEPTH-1];

  generate
    if (ID_BITS <= ptt_pkg::IN_ID_W) begin : g_id_trunc
      assign key_id_in = in_task_id[ID_BITS-1:0];
    end else begin : g_id_ext
      assign key_id_in = {{(ID_BITS - ptt_pkg::IN_ID_W){1'b0}}, in_task_id};
    end
  endgenerate

  // command latch
  always_ff @(posedge clk) begin
    if (take) begin
      kind_r     <= in_kind;
      key_id_r   <= key_id_in;
      key_prio_r <= in_task_priority;
    end
  end

  // per-command decode, evaluated in the execute cycle
  always_comb begin
    ctrl.do_ins    = 1'b0;
    ctrl.do_rem    = 1'b0;
    count_nxt      = count_r;
    out_acc_nxt    = 1'b0;
    out_status_nxt = ptt_pkg::ST_OK;
    if (busy_r) begin
      unique case (kind_r)
        ptt_pkg::KIND_INSERT: begin
          if (full) begin
            out_status_nxt = ptt_pkg::ST_FULL;
          end else if (key_prio_r == ptt_pkg::PRIO_NONE) begin
            out_status_nxt = ptt_pkg::ST_BAD_PRIO;
          end else begin
            ctrl.do_ins = 1'b1;
            out_acc_nxt = 1'b1;
            count_nxt   = count_r + CNT_W'(1);
          end
        end
        ptt_pkg::KIND_REMOVE: begin
          ctrl.do_rem = 1'b1;
          if (found) begin
            out_acc_nxt = 1'b1;
            count_nxt   = count_r - CNT_W'(1);
          end else begin
            out_status_nxt = ptt_pkg::ST_NOT_FOUND;
          end
        end
        ptt_pkg::KIND_CLEAR: begin
          out_acc_nxt = 1'b1;
          count_nxt   = '0;
        end
        default: begin
          out_acc_nxt = 1'b0;
        end
      endcase
    end
  end

  assign busy_nxt = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      out_acc_r    <= out_acc_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  // cell chain
  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      logic                       p_after;
      logic                       h_in;
      logic [ID_BITS-1:0]         p_id;
      logic [ptt_pkg::PRIO_W-1:0] p_prio;
      logic [ID_BITS-1:0]         n_id;
      logic [ptt_pkg::PRIO_W-1:0] n_prio;

      assign occ[gi] = (CNT_W'(gi) < count_r);

      if (gi == 0) begin : g_first
        assign p_after = 1'b0;
        assign h_in    = 1'b0;
        assign p_id    = key_id_r;
        assign p_prio  = key_prio_r;
      end else begin : g_mid
        assign p_after = after[gi-1];
        assign h_in    = hit[gi-1];
        assign p_id    = cell_id[gi-1];
        assign p_prio  = cell_prio[gi-1];
      end

      if (gi == TABLE_DEPTH - 1) begin : g_last
        assign n_id   = cell_id[gi];
        assign n_prio = cell_prio[gi];
      end else begin : g_inner
        assign n_id   = cell_id[gi+1];
        assign n_prio = cell_prio[gi+1];
      end

      ptt_cell #(
        .ID_BITS (ID_BITS)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .key_id     (key_id_r),
        .key_prio   (key_prio_r),
        .occ        (occ[gi]),
        .prev_after (p_after),
        .after_o    (after[gi]),
        .hit_in     (h_in),
        .hit_out    (hit[gi]),
        .prev_id    (p_id),
        .prev_prio  (p_prio),
        .next_id    (n_id),
        .next_prio  (n_prio),
        .id_o       (cell_id[gi]),
        .prio_o     (cell_prio[gi])
      );
    end
  endgenerate

  // result beat
  assign out_valid    = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_status   = out_status_r;

  generate
    if (CNT_W >= ptt_pkg::OUT_CNT_W) begin : g_cnt_trunc
      assign out_entry_count = count_r[ptt_pkg::OUT_CNT_W-1:0];
    end else begin : g_cnt_ext
      assign out_entry_count = {{(ptt_pkg::OUT_CNT_W - CNT_W){1'b0}}, count_r};
    end
  endgenerate

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count above table depth");

  a_exec_then_beat: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> out_valid_r)
    else $error("missing result beat after execute cycle");

  a_beat_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy_r))
    else $error("result beat without a command");

  a_take_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> busy_r)
    else $error("command taken but not executing");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ptt_pkg::ST_FULL) |-> (count_r == CNT_FULL))
    else $error("full status reported on a table with room");
`endif

endmodule
`default_nettype wire
